// ===== hdl/kfp_pkg.sv =====
`default_nettype none

package kfp_pkg;

    localparam int VALUE_BITS = 31;
    localparam int KEY_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int KEY_CHARS  = 3;
    localparam int KEY_BITS   = KEY_CHARS * BYTE_W;
    localparam int NUM_KEYS   = 10;

    // request queue between classifier and parser
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [KEY_W-1:0]  KEY_UNKNOWN = 4'd10;
    localparam logic [BYTE_W-1:0] CH_BAR      = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_EQ       = 8'h3D;

    localparam logic [KEY_BITS-1:0] KEY_TABLE [NUM_KEYS] = '{
        24'h554443,   // UDC
        24'h494443,   // IDC
        24'h554C31,   // UL1
        24'h494C31,   // IL1
        24'h504143,   // PAC
        24'h50524C,   // PRL
        24'h544B4B,   // TKK
        24'h544E46,   // TNF
        24'h4B4459,   // KDY
        24'h4B4C44    // KLD
    };

    typedef enum logic [2:0] {
        CL_BAR,
        CL_SEMI,
        CL_EQ,
        CL_HEX,
        CL_OTHER
    } char_class_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              first;
        char_class_t       cls;
        logic [3:0]        digit;
    } tok_t;

    function automatic logic [KEY_W-1:0] key_lookup(input logic [KEY_BITS-1:0] k);
        logic [KEY_W-1:0] code;
        logic             found;
        code  = KEY_UNKNOWN;
        found = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (!found && KEY_TABLE[i] == k)
            begin
                code  = 4'(i);
                found = 1'b1;
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/kfp_front.sv =====
`default_nettype none

module kfp_front (
    input  wire logic [kfp_pkg::BYTE_W-1:0] byte_req,
    input  wire logic                       first,
    output kfp_pkg::tok_t                   tok
);

    logic is_dec;
    logic is_lower;
    logic is_upper;

    assign is_dec   = (byte_req >= 8'h30) && (byte_req <= 8'h39);
    assign is_lower = (byte_req >= 8'h61) && (byte_req <= 8'h66);
    assign is_upper = (byte_req >= 8'h41) && (byte_req <= 8'h46);

    always_comb
    begin
        tok.ch    = byte_req;
        tok.first = first;
        // letters a-f and A-F carry 1..6 in the low nibble
        tok.digit = is_dec ? byte_req[3:0] : 4'(byte_req[3:0] + 4'd9);
        priority if (byte_req == kfp_pkg::CH_BAR)
            tok.cls = kfp_pkg::CL_BAR;
        else if (byte_req == kfp_pkg::CH_SEMI)
            tok.cls = kfp_pkg::CL_SEMI;
        else if (byte_req == kfp_pkg::CH_EQ)
            tok.cls = kfp_pkg::CL_EQ;
        else if (is_dec || is_lower || is_upper)
            tok.cls = kfp_pkg::CL_HEX;
        else
            tok.cls = kfp_pkg::CL_OTHER;
    end

endmodule

`default_nettype wire

// ===== hdl/kfp_queue.sv =====
`default_nettype none

module kfp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire kfp_pkg::tok_t tok_in,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output kfp_pkg::tok_t      tok_out
);

    kfp_pkg::tok_t                 entry_reg [kfp_pkg::Q_DEPTH];
    logic [kfp_pkg::Q_PTR_W-1:0]   head_reg;
    logic [kfp_pkg::Q_PTR_W-1:0]   tail_reg;
    logic [kfp_pkg::Q_CNT_W-1:0]   count_reg;

    assign full    = (count_reg == kfp_pkg::Q_CNT_W'(kfp_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign tok_out = entry_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail_reg] <= tok_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= (tail_reg == kfp_pkg::Q_PTR_W'(kfp_pkg::Q_DEPTH - 1))
                            ? '0 : kfp_pkg::Q_PTR_W'(tail_reg + 1'b1);
            if (pop)
                head_reg <= (head_reg == kfp_pkg::Q_PTR_W'(kfp_pkg::Q_DEPTH - 1))
                            ? '0 : kfp_pkg::Q_PTR_W'(head_reg + 1'b1);
            if (push && !pop)
                count_reg <= kfp_pkg::Q_CNT_W'(count_reg + 1'b1);
            else if (pop && !push)
                count_reg <= kfp_pkg::Q_CNT_W'(count_reg - 1'b1);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kfp_back.sv =====
`default_nettype none

module kfp_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire kfp_pkg::tok_t                  tok,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [kfp_pkg::KEY_W-1:0]           key_code,
    output logic [kfp_pkg::VALUE_BITS-1:0]      value,
    output logic                                frame_end
);

    localparam int VB = kfp_pkg::VALUE_BITS;

    logic [1:0]                   bar_reg,   bar_c,   bar_next;
    logic [1:0]                   skip_reg,  skip_c,  skip_next;
    logic [kfp_pkg::KEY_BITS-1:0] key_reg,   key_c,   key_next;
    logic [2:0]                   klen_reg,  klen_c,  klen_next;
    logic                         inval_reg, inval_c, inval_next;
    logic [VB-1:0]                acc_reg,   acc_c,   acc_next;
    logic                         bad_reg,   bad_c,   bad_next;
    logic                         done_reg,  done_c,  done_next;

    logic                         emit;
    logic                         emit_end;
    logic [kfp_pkg::KEY_W-1:0]    emit_code;
    logic [VB-1:0]                emit_value;

    logic                         out_valid_reg;
    logic [kfp_pkg::KEY_W-1:0]    key_code_reg;
    logic [VB-1:0]                value_reg;
    logic                         frame_end_reg;

    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign key_code  = key_code_reg;
    assign value     = value_reg;
    assign frame_end = frame_end_reg;

    // first byte of a response clears everything before it is handled
    always_comb
    begin
        bar_c   = tok.first ? 2'd0 : bar_reg;
        skip_c  = tok.first ? 2'd0 : skip_reg;
        key_c   = tok.first ? '0   : key_reg;
        klen_c  = tok.first ? 3'd0 : klen_reg;
        inval_c = tok.first ? 1'b0 : inval_reg;
        acc_c   = tok.first ? '0   : acc_reg;
        bad_c   = tok.first ? 1'b0 : bad_reg;
        done_c  = tok.first ? 1'b0 : done_reg;
    end

    assign emit_code  = (inval_c && klen_c == 3'd3) ? kfp_pkg::key_lookup(key_c)
                                                    : kfp_pkg::KEY_UNKNOWN;
    assign emit_value = (inval_c && !bad_c) ? acc_c : '0;

    always_comb
    begin
        bar_next   = bar_c;
        skip_next  = skip_c;
        key_next   = key_c;
        klen_next  = klen_c;
        inval_next = inval_c;
        acc_next   = acc_c;
        bad_next   = bad_c;
        done_next  = done_c;
        emit       = 1'b0;
        emit_end   = 1'b0;

        if (bar_c != 2'd2)
        begin
            priority if (tok.cls == kfp_pkg::CL_BAR)
            begin
                if (bar_c == 2'd0)
                begin
                    bar_next  = 2'd1;
                    skip_next = 2'd0;
                end
                else
                begin
                    bar_next = 2'd2;
                    emit     = 1'b1;
                    emit_end = 1'b1;
                end
            end
            else if (bar_c == 2'd0)
            begin
                // outside the section: drop
            end
            else if (skip_c != 2'd3)
                skip_next = 2'(skip_c + 2'd1);
            else if (tok.cls == kfp_pkg::CL_SEMI)
                emit = 1'b1;
            else if (!inval_c)
            begin
                if (tok.cls == kfp_pkg::CL_EQ)
                    inval_next = 1'b1;
                else
                begin
                    if (klen_c < 3'd3)
                        key_next = {key_c[kfp_pkg::KEY_BITS-kfp_pkg::BYTE_W-1:0], tok.ch};
                    if (klen_c < 3'd4)
                        klen_next = 3'(klen_c + 3'd1);
                end
            end
            else if (done_c)
            begin
                // value closed by a second '=': drop until field end
            end
            else if (tok.cls == kfp_pkg::CL_EQ)
                done_next = 1'b1;
            else if (bad_c)
            begin
                // value already invalid
            end
            else if (tok.cls != kfp_pkg::CL_HEX || acc_c[VB-1:VB-4] != 4'd0)
                bad_next = 1'b1;
            else
                acc_next = {acc_c[VB-5:0], tok.digit};
        end

        // a field end, and the opening '|', start a fresh field
        if (emit || (tok.cls == kfp_pkg::CL_BAR && bar_c == 2'd0))
        begin
            key_next   = '0;
            klen_next  = 3'd0;
            inval_next = 1'b0;
            acc_next   = '0;
            bad_next   = 1'b0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_reg       <= 2'd0;
            skip_reg      <= 2'd0;
            key_reg       <= '0;
            klen_reg      <= 3'd0;
            inval_reg     <= 1'b0;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                bar_reg       <= bar_next;
                skip_reg      <= skip_next;
                key_reg       <= key_next;
                klen_reg      <= klen_next;
                inval_reg     <= inval_next;
                acc_reg       <= acc_next;
                bad_reg       <= bad_next;
                done_reg      <= done_next;
                out_valid_reg <= emit;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            key_code_reg  <= emit_code;
            value_reg     <= emit_value;
            frame_end_reg <= emit_end;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/key_hex_field_parser.sv =====
// key_hex_field_parser: byte-serial parser of "...|xxxKEY=HEX;KEY=HEX|..." responses.
// Input channel: in_valid/in_stall carry one request per cycle, byte_req plus
//   first, which marks the first byte of a response and clears the parse state.
// Output channel: out_valid/out_stall carry one result per closed field:
//   key_code (10 = unknown), value (hex, 0 when invalid or too wide) and
//   frame_end, set when the second '|' closed the field.
// Only the section between the first and second '|' is parsed; its first three
//   characters are skipped.
// The byte that closes a field is written into the request queue when it is
//   accepted; the parser pops it from there, and the pop moves the parser
//   result into the output register.
// Throughput: one byte per cycle while the receiver does not stall; the parser
//   state is updated for each popped byte and the two-entry queue buffers requests.
// Reset clears the parse state, the queue and the output valid.
// A stalled receiver holds the result register; the parser stops, the queue
//   fills and in_stall rises when both queue entries are in use.
`default_nettype none

module key_hex_field_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [kfp_pkg::BYTE_W-1:0]     byte_req,
    input  wire logic                           first,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [kfp_pkg::KEY_W-1:0]           key_code,
    output logic [kfp_pkg::VALUE_BITS-1:0]      value,
    output logic                                frame_end
);

    kfp_pkg::tok_t front_tok;
    kfp_pkg::tok_t q_tok;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          q_push;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    kfp_front u_front (
        .byte_req (byte_req),
        .first    (first),
        .tok      (front_tok)
    );

    kfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .tok_in  (front_tok),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .tok_out (q_tok)
    );

    kfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .tok       (q_tok),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_code  (key_code),
        .value     (value),
        .frame_end (frame_end)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("queue pushed while full");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_code <= kfp_pkg::KEY_UNKNOWN)
        else $error("key code out of range");

    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && q_valid) |-> !q_pop)
        else $error("parser advanced while result held");

endmodule

`default_nettype wire
